// ===== design/four_channel_pid_heater_control_unit_defines.svh =====
// Assertion macros for the heater control RTL.
`ifndef FOUR_CHANNEL_PID_HEATER_CONTROL_UNIT_DEFINES_SVH
`define FOUR_CHANNEL_PID_HEATER_CONTROL_UNIT_DEFINES_SVH

// Plain property, checked out of reset.
`define HCTL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define HCTL_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// ===== design/hctl_pkg.sv =====
package hctl_pkg;

  localparam int unsigned NUM_CH   = 4;
  localparam int unsigned CH_IDX_W = $clog2(NUM_CH);
  localparam int unsigned SP_W     = 14;
  localparam int unsigned TEMP_W   = 16;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned INTV_W   = 20;
  localparam int unsigned ERR_W    = 18;
  localparam int unsigned NOW_W    = 32;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 5;

  localparam int unsigned DEF_INTEGRAL_WIDTH = 32;
  localparam int unsigned DEF_TIME_WIDTH     = 32;

  localparam logic signed [SP_W-1:0]   SP_MAX     = 14'sd5120;
  localparam logic signed [SP_W-1:0]   SP_MIN     = -14'sd5120;
  localparam logic signed [TEMP_W-1:0] TEMP_BB_HI = 16'sd6400;
  localparam logic signed [TEMP_W-1:0] TEMP_BB_LO = -16'sd6400;

  typedef enum logic [2:0] {
    REG_SP0      = 3'd0,
    REG_SP1      = 3'd1,
    REG_SP2      = 3'd2,
    REG_SP3      = 3'd3,
    REG_GAIN_P   = 3'd4,
    REG_GAIN_I   = 3'd5,
    REG_GAIN_D   = 3'd6,
    REG_INTERVAL = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [NUM_CH-1:0][SP_W-1:0] setpoint;
    logic [GAIN_W-1:0]           gain_p;
    logic [GAIN_W-1:0]           gain_i;
    logic [GAIN_W-1:0]           gain_d;
    logic [INTV_W-1:0]           interval;
  } cfg_t;

  typedef struct packed {
    logic [SP_W-1:0]   setpoint;
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
  } chan_cfg_t;

  typedef struct packed {
    logic heat;
    logic bang;
  } chan_res_t;

endpackage

// ===== design/hctl_cfg_regs.sv =====
module hctl_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hctl_pkg::APB_AW-1:0] paddr,
  input  logic [hctl_pkg::APB_DW-1:0] pwdata,
  output logic [hctl_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output hctl_pkg::cfg_t             cfg_o
);

  hctl_pkg::cfg_t     cfg_q, cfg_d;
  hctl_pkg::reg_idx_e idx;
  logic signed [hctl_pkg::SP_W-1:0] wr_sp;
  logic [hctl_pkg::CH_IDX_W-1:0]    ch_idx;
  logic                             wr_en;

  assign idx    = hctl_pkg::reg_idx_e'(paddr[hctl_pkg::APB_AW-1:2]);
  assign ch_idx = paddr[hctl_pkg::CH_IDX_W+1:2];
  assign wr_sp  = $signed(pwdata[hctl_pkg::SP_W-1:0]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx) inside
        hctl_pkg::REG_SP0, hctl_pkg::REG_SP1, hctl_pkg::REG_SP2, hctl_pkg::REG_SP3: begin
          // out-of-range setpoints are dropped
          if (wr_sp >= hctl_pkg::SP_MIN && wr_sp <= hctl_pkg::SP_MAX) begin
            cfg_d.setpoint[ch_idx] = wr_sp;
          end
        end
        hctl_pkg::REG_GAIN_P:   cfg_d.gain_p   = pwdata[hctl_pkg::GAIN_W-1:0];
        hctl_pkg::REG_GAIN_I:   cfg_d.gain_i   = pwdata[hctl_pkg::GAIN_W-1:0];
        hctl_pkg::REG_GAIN_D:   cfg_d.gain_d   = pwdata[hctl_pkg::GAIN_W-1:0];
        hctl_pkg::REG_INTERVAL: cfg_d.interval = pwdata[hctl_pkg::INTV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx) inside
      hctl_pkg::REG_SP0, hctl_pkg::REG_SP1, hctl_pkg::REG_SP2, hctl_pkg::REG_SP3: begin
        prdata = hctl_pkg::APB_DW'(cfg_q.setpoint[ch_idx]);
      end
      hctl_pkg::REG_GAIN_P:   prdata = hctl_pkg::APB_DW'(cfg_q.gain_p);
      hctl_pkg::REG_GAIN_I:   prdata = hctl_pkg::APB_DW'(cfg_q.gain_i);
      hctl_pkg::REG_GAIN_D:   prdata = hctl_pkg::APB_DW'(cfg_q.gain_d);
      hctl_pkg::REG_INTERVAL: prdata = hctl_pkg::APB_DW'(cfg_q.interval);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/hctl_channel.sv =====
module hctl_channel #(
  parameter int unsigned INTEGRAL_WIDTH = hctl_pkg::DEF_INTEGRAL_WIDTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hctl_pkg::chan_cfg_t         cfg_i,
  input  logic [hctl_pkg::TEMP_W-1:0] temp_i,
  input  logic                        step_i,
  output hctl_pkg::chan_res_t         res_o
);

  localparam int unsigned IW  = INTEGRAL_WIDTH;
  localparam int unsigned DW  = hctl_pkg::ERR_W + 1;
  localparam int unsigned PW  = hctl_pkg::GAIN_W + hctl_pkg::ERR_W;
  localparam int unsigned IPW = hctl_pkg::GAIN_W + IW;
  localparam int unsigned DPW = hctl_pkg::GAIN_W + DW;
  localparam int unsigned YW  = IW + 18;

  localparam logic signed [IW-1:0] INT_MAX = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0] INT_MIN = {1'b1, {(IW-1){1'b0}}};

  logic signed [IW-1:0]                 integral_q, integral_d;
  logic signed [hctl_pkg::ERR_W-1:0]    last_err_q;
  logic signed [hctl_pkg::SP_W-1:0]     sp;
  logic signed [hctl_pkg::TEMP_W-1:0]   temp;
  logic signed [hctl_pkg::GAIN_W-1:0]   gp, gi, gd;
  logic signed [hctl_pkg::ERR_W-1:0]    err;
  logic signed [IW:0]                   s_wide;
  logic signed [DW-1:0]                 deriv;
  logic signed [PW-1:0]                 prod_p;
  logic signed [IPW-1:0]                prod_i;
  logic signed [DPW-1:0]                prod_d;
  logic signed [YW-1:0]                 y;
  logic                                 is_bang;
  logic                                 pid_heat;

  assign sp   = $signed(cfg_i.setpoint);
  assign temp = $signed(temp_i);
  assign gp   = $signed(cfg_i.gain_p);
  assign gi   = $signed(cfg_i.gain_i);
  assign gd   = $signed(cfg_i.gain_d);

  assign is_bang = (temp < hctl_pkg::TEMP_BB_LO) || (temp > hctl_pkg::TEMP_BB_HI);

  assign err    = hctl_pkg::ERR_W'(sp) - hctl_pkg::ERR_W'(temp);
  assign s_wide = (IW+1)'(integral_q) + (IW+1)'(err);
  assign deriv  = DW'(err) - DW'(last_err_q);

  always_comb begin
    if (s_wide[IW] != s_wide[IW-1]) begin
      integral_d = s_wide[IW] ? INT_MIN : INT_MAX;
    end else begin
      integral_d = s_wide[IW-1:0];
    end
  end

  assign prod_p = gp * err;
  assign prod_i = gi * integral_d;
  assign prod_d = gd * deriv;
  assign y      = YW'(prod_p) + YW'(prod_i) + YW'(prod_d);

  assign pid_heat = !y[YW-1] && (y != '0);

  assign res_o.bang = is_bang;
  assign res_o.heat = is_bang ? (temp <= sp) : pid_heat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q <= '0;
      last_err_q <= '0;
    end else if (step_i && !is_bang) begin
      integral_q <= integral_d;
      last_err_q <= err;
    end
  end

endmodule

// ===== design/four_channel_pid_heater_control_unit.sv =====
// Four-channel heater controller, PID with bang-bang fallback.
// Input channel: in_valid_i/in_stall_o carries one frame per transaction
// (timestamp, four Q7.8 temperatures, reported heater bits).
// Output channel: out_valid_o/out_stall_i returns exactly one result per
// frame (heater commands, bang-bang mask, control-applied flag).
// The frame sits in the input register while the four channel datapaths and
// the interval check evaluate, then lands in the result register.
// Throughput: one frame per cycle while out_stall_i is low; the per-channel
// integral and last error update in the same cycle the frame leaves the
// input register, so the next frame sees them immediately.
// Configuration goes through the APB port (byte address 4*index); the user
// must write it only while idle, as the block itself does not enforce this.
// Reset clears the valid flags, the configuration registers, the integrals,
// the last errors and the last control time; control stays disabled until a
// nonzero interval is written.
// While the receiver stalls, the result holds; one more frame is taken into
// the input register, then in_stall_o rises until the result is taken.
`include "four_channel_pid_heater_control_unit_defines.svh"

module four_channel_pid_heater_control_unit #(
  parameter int unsigned INTEGRAL_WIDTH = hctl_pkg::DEF_INTEGRAL_WIDTH,
  parameter int unsigned TIME_WIDTH     = hctl_pkg::DEF_TIME_WIDTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hctl_pkg::APB_AW-1:0] paddr,
  input  logic [hctl_pkg::APB_DW-1:0] pwdata,
  output logic [hctl_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [hctl_pkg::NOW_W-1:0]  now_us_i,
  input  logic [hctl_pkg::TEMP_W-1:0] temp_ch0_i,
  input  logic [hctl_pkg::TEMP_W-1:0] temp_ch1_i,
  input  logic [hctl_pkg::TEMP_W-1:0] temp_ch2_i,
  input  logic [hctl_pkg::TEMP_W-1:0] temp_ch3_i,
  input  logic [hctl_pkg::NUM_CH-1:0] heater_reported_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [hctl_pkg::NUM_CH-1:0] heater_on_o,
  output logic [hctl_pkg::NUM_CH-1:0] bang_bang_channels_o,
  output logic                        control_applied_o
);

  localparam int unsigned TW = TIME_WIDTH;

  hctl_pkg::cfg_t cfg;

  logic                                              in_valid_q;
  logic [hctl_pkg::NOW_W-1:0]                        now_q;
  logic [hctl_pkg::NUM_CH-1:0][hctl_pkg::TEMP_W-1:0] temp_q;
  logic [hctl_pkg::NUM_CH-1:0]                       rep_q;

  logic                        out_valid_q;
  logic [hctl_pkg::NUM_CH-1:0] heat_q, heat_d;
  logic [hctl_pkg::NUM_CH-1:0] bang_q, bang_d;
  logic                        applied_q, applied_d;

  logic [TW-1:0]                      last_time_q;
  logic [TW+hctl_pkg::NOW_W-1:0]      now_ext;
  logic [TW-1:0]                      now_tw;
  logic [TW-1:0]                      elapsed;
  logic [TW-1:0]                      interval_ext;
  logic                               in_fire;
  logic                               advance;
  logic                               ctl_enabled;
  logic                               step_due;
  logic                               ctl_step;

  hctl_pkg::chan_cfg_t [hctl_pkg::NUM_CH-1:0] chan_cfg;
  hctl_pkg::chan_res_t [hctl_pkg::NUM_CH-1:0] chan_res;
  logic [hctl_pkg::NUM_CH-1:0]                ch_heat;
  logic [hctl_pkg::NUM_CH-1:0]                ch_bang;

  hctl_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      now_q     <= now_us_i;
      temp_q[0] <= temp_ch0_i;
      temp_q[1] <= temp_ch1_i;
      temp_q[2] <= temp_ch2_i;
      temp_q[3] <= temp_ch3_i;
      rep_q     <= heater_reported_i;
    end
  end

  // timestamp taken modulo 2^TW
  assign now_ext      = {{TW{1'b0}}, now_q};
  assign now_tw       = now_ext[TW-1:0];
  assign elapsed      = now_tw - last_time_q;
  assign interval_ext = {{(TW-hctl_pkg::INTV_W){1'b0}}, cfg.interval};
  assign ctl_enabled  = (cfg.interval != '0);
  assign step_due     = ctl_enabled && (elapsed >= interval_ext);
  assign ctl_step     = advance && step_due;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q <= '0;
    end else if (ctl_step) begin
      last_time_q <= now_tw;
    end
  end

  for (genvar g = 0; g < hctl_pkg::NUM_CH; g++) begin : g_ch
    assign chan_cfg[g].setpoint = cfg.setpoint[g];
    assign chan_cfg[g].gain_p   = cfg.gain_p;
    assign chan_cfg[g].gain_i   = cfg.gain_i;
    assign chan_cfg[g].gain_d   = cfg.gain_d;

    hctl_channel #(
      .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_channel (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cfg_i  (chan_cfg[g]),
      .temp_i (temp_q[g]),
      .step_i (ctl_step),
      .res_o  (chan_res[g])
    );

    assign ch_heat[g] = chan_res[g].heat;
    assign ch_bang[g] = chan_res[g].bang;
  end

  always_comb begin
    if (!ctl_enabled) begin
      heat_d    = '0;
      bang_d    = '0;
      applied_d = 1'b0;
    end else if (step_due) begin
      heat_d    = ch_heat;
      bang_d    = ch_bang;
      applied_d = 1'b1;
    end else begin
      heat_d    = rep_q;
      bang_d    = '0;
      applied_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      heat_q    <= heat_d;
      bang_q    <= bang_d;
      applied_q <= applied_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign heater_on_o          = heat_q;
  assign bang_bang_channels_o = bang_q;
  assign control_applied_o    = applied_q;

  `HCTL_ASSERT_NEXT(a_off_dis, advance && !ctl_enabled, out_valid_q && heat_q == '0, "heat on")
  `HCTL_ASSERT_NEXT(a_time_stored, ctl_step, last_time_q == $past(now_tw), "time not stored")
  `HCTL_ASSERT_NEXT(a_time_kept, !ctl_step, $stable(last_time_q), "time changed without step")
  `HCTL_ASSERT(a_bang_step, out_valid_q && !applied_q |-> bang_q == '0, "bang mask without step")

endmodule

// ===== verif/four_channel_pid_heater_control_unit_tb.sv =====
`timescale 1ns / 1ps

module four_channel_pid_heater_control_unit_tb;

  localparam int unsigned NUM_CH = hctl_pkg::NUM_CH;
  localparam int unsigned NOW_W  = hctl_pkg::NOW_W;
  localparam int unsigned TEMP_W = hctl_pkg::TEMP_W;
  localparam int unsigned SP_W   = hctl_pkg::SP_W;
  localparam int unsigned GAIN_W = hctl_pkg::GAIN_W;
  localparam int unsigned INTV_W = hctl_pkg::INTV_W;
  localparam int unsigned ERR_W  = hctl_pkg::ERR_W;
  localparam int unsigned APB_AW = hctl_pkg::APB_AW;
  localparam int unsigned APB_DW = hctl_pkg::APB_DW;

  localparam int unsigned MAX_CYCLES  = 100_000;
  localparam int unsigned RAND_PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 240;
  localparam int unsigned SAT_FRAMES  = 40;
  localparam int unsigned IDLE_PCT    = 18;
  localparam int unsigned INTG_W      = hctl_pkg::DEF_INTEGRAL_WIDTH;
  localparam longint      INTEG_MAX   = (longint'(1) << (INTG_W - 1)) - 1;
  localparam longint      INTEG_MIN   = -(longint'(1) << (INTG_W - 1));

  typedef struct packed {
    logic [NOW_W-1:0]              now_us;
    logic [NUM_CH-1:0][TEMP_W-1:0] temp;
    logic [NUM_CH-1:0]             heater_rep;
  } frame_t;

  typedef struct packed {
    logic [NUM_CH-1:0] heat;
    logic [NUM_CH-1:0] bang;
    logic              applied;
  } heater_cmd_t;

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [APB_AW-1:0]   paddr   = '0;
  logic [APB_DW-1:0]   pwdata  = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [NUM_CH-1:0]   heater_on_o;
  logic [NUM_CH-1:0]   bang_bang_channels_o;
  logic                control_applied_o;
  frame_t              cur_frame = '0;

  four_channel_pid_heater_control_unit DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .now_us_i             (cur_frame.now_us),
    .temp_ch0_i           (cur_frame.temp[0]),
    .temp_ch1_i           (cur_frame.temp[1]),
    .temp_ch2_i           (cur_frame.temp[2]),
    .temp_ch3_i           (cur_frame.temp[3]),
    .heater_reported_i    (cur_frame.heater_rep),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .heater_on_o          (heater_on_o),
    .bang_bang_channels_o (bang_bang_channels_o),
    .control_applied_o    (control_applied_o)
  );

  // mirror of the controller state and registers
  logic signed [SP_W-1:0]   sp_r [NUM_CH];
  logic signed [GAIN_W-1:0] gp_r, gi_r, gd_r;
  logic        [INTV_W-1:0] ctl_interval;
  logic signed [INTG_W-1:0] integ [NUM_CH];
  logic signed [ERR_W-1:0]  last_err [NUM_CH];
  logic        [NOW_W-1:0]  last_ctl_time;

  frame_t      frame_q[$];
  heater_cmd_t pending_cmds_q[$];
  logic        in_fire = 1'b0;
  bit          calm = 1'b0;
  int unsigned n_queued, n_accepted, n_checked, n_steps, n_bang, n_reg_writes;
  int unsigned mismatch_cnt, cycle_cnt;

  function automatic void mirror_reg_write(hctl_pkg::reg_idx_e idx, logic [APB_DW-1:0] data);
    logic signed [SP_W-1:0] sp;
    sp = data[SP_W-1:0];
    case (idx)
      hctl_pkg::REG_SP0, hctl_pkg::REG_SP1, hctl_pkg::REG_SP2, hctl_pkg::REG_SP3: begin
        if (sp >= hctl_pkg::SP_MIN && sp <= hctl_pkg::SP_MAX) sp_r[int'(idx)] = sp;
      end
      hctl_pkg::REG_GAIN_P:   gp_r = data[GAIN_W-1:0];
      hctl_pkg::REG_GAIN_I:   gi_r = data[GAIN_W-1:0];
      hctl_pkg::REG_GAIN_D:   gd_r = data[GAIN_W-1:0];
      hctl_pkg::REG_INTERVAL: ctl_interval = data[INTV_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic heater_cmd_t predict_heater_cmd(frame_t f);
    heater_cmd_t            r;
    logic signed [TEMP_W-1:0] t;
    longint                 e, s, d, y;
    int                     ch;
    r = '0;
    if (ctl_interval == '0) begin
      r.heat = '0;
    end else if ((f.now_us - last_ctl_time) >= ctl_interval) begin
      for (ch = 0; ch < NUM_CH; ch++) begin
        t = f.temp[ch];
        if (t < hctl_pkg::TEMP_BB_LO || t > hctl_pkg::TEMP_BB_HI) begin
          r.bang[ch] = 1'b1;
          if (!(t > sp_r[ch])) r.heat[ch] = 1'b1;
        end else begin
          e = longint'(sp_r[ch]) - longint'(t);
          s = longint'(integ[ch]) + e;
          if (s > INTEG_MAX) s = INTEG_MAX;
          if (s < INTEG_MIN) s = INTEG_MIN;
          integ[ch] = s[INTG_W-1:0];
          d = e - longint'(last_err[ch]);
          y = longint'(gp_r) * e + longint'(gi_r) * s + longint'(gd_r) * d;
          last_err[ch] = e[ERR_W-1:0];
          if (y > 0) r.heat[ch] = 1'b1;
        end
      end
      last_ctl_time = f.now_us;
      r.applied = 1'b1;
    end else begin
      r.heat = f.heater_rep;
    end
    return r;
  endfunction

  task automatic log_mismatch(string what, heater_cmd_t want, heater_cmd_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("mismatch (%s) at %0t: exp heat=%b bang=%b applied=%b,",
               what, $realtime, want.heat, want.bang, want.applied,
               " got heat=%b bang=%b applied=%b", got.heat, got.bang, got.applied);
  endtask

  task automatic add_frame(logic [NOW_W-1:0] now, logic [TEMP_W-1:0] t0, logic [TEMP_W-1:0] t1,
                           logic [TEMP_W-1:0] t2, logic [TEMP_W-1:0] t3, logic [NUM_CH-1:0] rep);
    frame_t f;
    f.now_us     = now;
    f.temp       = {t3, t2, t1, t0};
    f.heater_rep = rep;
    frame_q.push_back(f);
    n_queued++;
  endtask

  function automatic logic [TEMP_W-1:0] rand_temp();
    int v;
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      v = int'($urandom_range(12800)) - 6400;
    end else if (pick < 80) begin
      case ($urandom_range(3))
        0:       v = 6400;
        1:       v = -6400;
        2:       v = 6401;
        default: v = -6401;
      endcase
    end else begin
      v = $urandom;
    end
    return v[TEMP_W-1:0];
  endfunction

  task automatic apb_write(hctl_pkg::reg_idx_e idx, logic [APB_DW-1:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    mirror_reg_write(idx, data);
    n_reg_writes++;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic wait_idle();
    while (n_accepted != n_queued || pending_cmds_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin : watchdog
    while (cycle_cnt < MAX_CYCLES) @(posedge clk_i) cycle_cnt++;
    $display("RESULT: ERROR");
    $finish;
  end

  // driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (frame_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        cur_frame  <= frame_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= rst_ni && !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // monitor
  always @(posedge clk_i) begin
    heater_cmd_t want, got;
    if (rst_ni) begin
      in_fire <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        want = predict_heater_cmd(cur_frame);
        pending_cmds_q.push_back(want);
        n_accepted++;
        if (want.applied) n_steps++;
        n_bang += $countones(want.bang);
      end
      if (out_valid_o && !out_stall_i) begin
        got.heat    = heater_on_o;
        got.bang    = bang_bang_channels_o;
        got.applied = control_applied_o;
        if (pending_cmds_q.size() == 0) begin
          log_mismatch("no transaction pending", '0, got);
        end else begin
          want = pending_cmds_q.pop_front();
          n_checked++;
          if (got.heat !== want.heat || got.bang !== want.bang || got.applied !== want.applied)
            log_mismatch("field", want, got);
        end
      end
    end
  end

  initial begin : stimulus
    logic [NOW_W-1:0]  stim_now;
    logic [APB_DW-1:0] data;
    logic [INTV_W-1:0] intv;
    int unsigned       base;
    int                v, pick, ph, i, r;
    for (i = 0; i < NUM_CH; i++) begin
      sp_r[i]     = '0;
      integ[i]    = '0;
      last_err[i] = '0;
    end
    gp_r = '0;
    gi_r = '0;
    gd_r = '0;
    ctl_interval  = '0;
    last_ctl_time = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // control disabled out of reset
    for (i = 0; i < 3; i++) add_frame($urandom, rand_temp(), rand_temp(), rand_temp(),
                                      rand_temp(), NUM_CH'($urandom));
    wait_idle();

    apb_write(hctl_pkg::REG_SP0, 5120);
    apb_write(hctl_pkg::REG_SP1, -5120);
    apb_write(hctl_pkg::REG_SP2, 1000);
    apb_write(hctl_pkg::REG_SP3, -1);
    apb_write(hctl_pkg::REG_GAIN_P, 32767);
    apb_write(hctl_pkg::REG_GAIN_I, -32768);
    apb_write(hctl_pkg::REG_GAIN_D, 1);
    apb_write(hctl_pkg::REG_INTERVAL, 200000);
    add_frame(0, 0, 0, 0, 0, 4'b1010);
    add_frame(199999, 100, -100, 0, 0, 4'b0101);
    add_frame(200000, 32767, -32768, 6400, -6400, 4'b0000);
    add_frame(300000, 0, 0, 0, 0, 4'b1111);
    add_frame(400000, 6401, -6401, -6401, 6401, 4'b0000);
    add_frame(600000, 5120, -5120, 1000, -1, 4'b1111);
    add_frame(32'hFFFF_FFFF, -32768, 32767, 6400, -6400, 4'b0110);
    // timestamp wraps past zero
    add_frame(199999, 3000, -3000, 50, -50, 4'b1001);
    add_frame(200099, 0, 0, 0, 0, 4'b1001);
    wait_idle();

    // zero control output
    apb_write(hctl_pkg::REG_GAIN_P, 0);
    apb_write(hctl_pkg::REG_GAIN_I, 0);
    apb_write(hctl_pkg::REG_GAIN_D, 0);
    apb_write(hctl_pkg::REG_INTERVAL, 1);
    add_frame(500000, 0, 100, -100, 6400, 4'b1111);
    add_frame(500001, 5120, -5120, 1000, -1, 4'b1111);
    wait_idle();

    // out-of-range setpoint writes are dropped
    apb_write(hctl_pkg::REG_SP0, 5121);
    apb_write(hctl_pkg::REG_SP1, -5121);
    apb_write(hctl_pkg::REG_SP2, 32'hFFFF_2000);
    apb_write(hctl_pkg::REG_SP3, 32'hABCD_0000 | (32'(-5120) & 32'h3FFF));
    apb_write(hctl_pkg::REG_GAIN_P, 1);
    add_frame(600000, 5120, -5121, 999, -5121, 4'b0000);
    add_frame(600001, 5119, -5120, 1000, -5120, 4'b0000);
    wait_idle();

    stim_now = $urandom;
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      calm = (ph == 2);
      for (r = 0; r < NUM_CH; r++) begin
        pick = $urandom_range(99);
        if (pick < 60) data = int'($urandom_range(10240)) - 5120;
        else if (pick < 70) data = ($urandom_range(1) != 0) ? 5120 : -5120;
        else data = $urandom;
        apb_write(hctl_pkg::reg_idx_e'(r), data);
      end
      for (r = int'(hctl_pkg::REG_GAIN_P); r <= int'(hctl_pkg::REG_GAIN_D); r++) begin
        if ($urandom_range(99) < 30) begin
          case ($urandom_range(4))
            0:       data = -32768;
            1:       data = 32767;
            2:       data = 0;
            3:       data = 1;
            default: data = -1;
          endcase
        end else begin
          data = $urandom;
        end
        apb_write(hctl_pkg::reg_idx_e'(r), data);
      end
      case (ph)
        0:       intv = 200000;
        1:       intv = 1000000;
        2:       intv = 20'hFFFFF;
        3:       intv = 1;
        4:       intv = INTV_W'($urandom_range(1000000, 200000));
        default: intv = INTV_W'($urandom);
      endcase
      apb_write(hctl_pkg::REG_INTERVAL, {12'($urandom), intv});
      base = (intv == 0) ? 200000 : intv;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          stim_now = $urandom;
        end else if (pick < 25) begin
          stim_now += $urandom_range(base / 4);
        end else begin
          case ($urandom_range(3))
            0:       stim_now += base;
            1:       stim_now += base - 1;
            default: stim_now += $urandom_range(2 * base, base / 2);
          endcase
        end
        add_frame(stim_now, rand_temp(), rand_temp(), rand_temp(), rand_temp(),
                  NUM_CH'($urandom));
      end
      wait_idle();
    end

    // wind channel 0 integral up and channel 2 down, then unwind both
    calm = 1'b1;
    apb_write(hctl_pkg::REG_SP0, 5120);
    apb_write(hctl_pkg::REG_SP1, 0);
    apb_write(hctl_pkg::REG_SP2, -5120);
    apb_write(hctl_pkg::REG_SP3, 0);
    apb_write(hctl_pkg::REG_GAIN_P, 0);
    apb_write(hctl_pkg::REG_GAIN_I, 1);
    apb_write(hctl_pkg::REG_GAIN_D, 0);
    apb_write(hctl_pkg::REG_INTERVAL, 1);
    for (i = 0; i < SAT_FRAMES + 20; i++) begin
      v = $urandom_range(32767, 6401);
      if ($urandom_range(1) != 0) v = -v - 1;
      if (i < SAT_FRAMES)
        add_frame(32'hFFFF_0000 + i, -6400, TEMP_W'(int'($urandom_range(12800)) - 6400), 6400,
                  TEMP_W'(v), NUM_CH'($urandom));
      else
        add_frame(32'hFFFF_0000 + i, 6400, TEMP_W'(int'($urandom_range(12800)) - 6400), -6400,
                  TEMP_W'(v), NUM_CH'($urandom));
    end
    wait_idle();
    calm = 1'b0;

    $display("Covered %0d frames over %0d register writes:", n_accepted, n_reg_writes,
             " %0d control steps, %0d bang-bang decisions.", n_steps, n_bang);
    $display("Checked %0d results, %0d mismatches.", n_checked, mismatch_cnt);
    if (mismatch_cnt == 0 && pending_cmds_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/hctl_pkg.sv
design/hctl_cfg_regs.sv
design/hctl_channel.sv
design/four_channel_pid_heater_control_unit.sv
verif/four_channel_pid_heater_control_unit_tb.sv
